// ===== hw/rtl/assert_macros.svh =====
// assertion macros shared by the rtl modules
// expects signals clk and rst_n in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be seen at a rising edge outside reset
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== hw/rtl/wcd_pkg.sv =====
// shared types, codes and helpers of the walsh cdma spreader / despreader
// no dependencies
`default_nettype none

package wcd_pkg;

    localparam int STATIONS_DEF = 4;

    localparam int CMD_W   = 2;
    localparam int IDX_W   = 6;
    localparam int SYM_W   = 2;
    localparam int CHIP_W  = 8;
    localparam int DELTA_W = 3;
    localparam int ACC_W   = 14;
    localparam int MAG_W   = 13;
    localparam int QUO_W   = 7;

    typedef logic [CMD_W-1:0]          cmd_t;
    typedef logic [IDX_W-1:0]          idx_t;
    typedef logic signed [SYM_W-1:0]   sym_t;
    typedef logic signed [CHIP_W-1:0]  chip_t;
    typedef logic signed [DELTA_W-1:0] delta_t;
    typedef logic signed [ACC_W-1:0]   acc_t;
    typedef logic [MAG_W-1:0]          mag_t;
    typedef logic [QUO_W-1:0]          quo_t;

    localparam cmd_t CMD_WRITE  = 2'd0;
    localparam cmd_t CMD_LISTEN = 2'd1;
    localparam cmd_t CMD_READ   = 2'd2;

    localparam logic KIND_SYMBOL = 1'b0;
    localparam logic KIND_CHIP   = 1'b1;

    localparam sym_t SYM_ZERO = 2'sb00;
    localparam sym_t SYM_POS  = 2'sb01;
    localparam sym_t SYM_NEG  = 2'sb11;

    // true when chip col of the code for row is -1
    function automatic logic walsh_odd(idx_t row, idx_t col);
        walsh_odd = ^(row & col);
    endfunction

    // the -2 pattern saturates to -1
    function automatic sym_t sym_decode(logic [SYM_W-1:0] bits);
        sym_t s;
        unique case (bits)
            2'b00:   s = SYM_ZERO;
            2'b01:   s = SYM_POS;
            default: s = SYM_NEG;
        endcase
        sym_decode = s;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/wcd_if.sv =====
// request and response channel interfaces of the walsh cdma block
// depends on wcd_pkg
`default_nettype none

interface wcd_req_if;
    logic          valid;
    logic          ready;
    wcd_pkg::cmd_t command;
    wcd_pkg::idx_t station;
    logic [wcd_pkg::SYM_W-1:0] symbol;

    modport source (output valid, command, station, symbol, input ready);
    modport sink (input valid, command, station, symbol, output ready);
endinterface

interface wcd_rsp_if;
    logic           valid;
    logic           ready;
    logic           kind;
    wcd_pkg::chip_t value;

    modport source (output valid, kind, value, input ready);
    modport sink (input valid, kind, value, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/wcd_cell.sv =====
// one ring cell: holds a channel chip and a station symbol
// hands both to its neighbor on every shift; depends on wcd_pkg
`default_nettype none

module wcd_cell (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           shift,
    input  wire wcd_pkg::chip_t chip_in,
    input  wire wcd_pkg::sym_t  sym_in,
    output      wcd_pkg::chip_t chip,
    output      wcd_pkg::sym_t  sym
);

    wcd_pkg::chip_t chip_reg;
    wcd_pkg::sym_t  sym_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chip_reg <= '0;
            sym_reg  <= wcd_pkg::SYM_ZERO;
        end
        else if (shift)
        begin
            chip_reg <= chip_in;
            sym_reg  <= sym_in;
        end
    end

    assign chip = chip_reg;
    assign sym  = sym_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/wcd_div.sv =====
// reciprocal-multiply divider of a correlation magnitude by STATIONS
// captures the magnitude, then multiplies and keeps the high bits; depends on wcd_pkg
`default_nettype none

module wcd_div #(
    parameter int STATIONS = wcd_pkg::STATIONS_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire wcd_pkg::mag_t dividend,
    output      logic          done,
    output      wcd_pkg::quo_t quotient
);

    // floor(n / STATIONS) equals floor(n * RECIP / 2**SHIFT) for every n below 2**MAG_W
    localparam int SHIFT   = wcd_pkg::MAG_W + $clog2(STATIONS);
    localparam int RECIP_W = wcd_pkg::MAG_W + 2;
    localparam int PROD_W  = wcd_pkg::MAG_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((2 ** SHIFT) / STATIONS + 1);

    wcd_pkg::mag_t     mag_reg;
    wcd_pkg::quo_t     quo_reg;
    logic              stage_reg;
    logic              done_reg;
    logic [PROD_W-1:0] product;

    assign product = PROD_W'(mag_reg) * PROD_W'(RECIP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            stage_reg <= start;
            done_reg  <= stage_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mag_reg <= dividend;
        end
        if (stage_reg)
        begin
            quo_reg <= product[SHIFT +: wcd_pkg::QUO_W];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/walsh_cdma_spread_despread.sv =====
// walsh cdma spreader / despreader: a ring of STATIONS cells rotates one chip per cycle while a pass runs
// write: a symbol pass, then a spread pass, then back to idle
// listen: a correlation pass over the ring, then the divider, then the finish state
// read: a full pass for the ring to come around, then the finish state
// asynchronous active-low reset clears all symbols and chips, no clearing pass
// one request at a time; a stalled response holds the next result in its finish state
`default_nettype none
`include "assert_macros.svh"

module walsh_cdma_spread_despread #(
    parameter int STATIONS = wcd_pkg::STATIONS_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    wcd_req_if.sink   req,
    wcd_rsp_if.source rsp
);

    localparam int STEP_W = $clog2(STATIONS);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(STATIONS - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SPREAD,
        ST_LISTEN,
        ST_READ,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

    state_t              state_reg, state_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    wcd_pkg::idx_t       idx_reg, idx_next;
    wcd_pkg::sym_t       new_sym_reg, new_sym_next;
    wcd_pkg::sym_t       old_sym_reg, old_sym_next;
    wcd_pkg::acc_t       acc_reg, acc_next;
    logic                neg_reg, neg_next;
    logic                res_kind_reg, res_kind_next;
    wcd_pkg::chip_t      res_value_reg, res_value_next;
    logic                out_valid_reg, out_valid_next;
    logic                out_kind_reg, out_kind_next;
    wcd_pkg::chip_t      out_value_reg, out_value_next;

    wcd_pkg::chip_t chip_w [STATIONS];
    wcd_pkg::sym_t  sym_w  [STATIONS];
    wcd_pkg::chip_t ring_chip_in;
    wcd_pkg::sym_t  ring_sym_in;
    logic           shift;
    logic           step_hit;
    logic           odd;
    wcd_pkg::delta_t delta;
    wcd_pkg::acc_t  term;
    wcd_pkg::acc_t  acc_sum;
    wcd_pkg::acc_t  acc_abs;
    logic           div_start;
    logic           div_done;
    wcd_pkg::quo_t  quotient;
    wcd_pkg::chip_t quo_ext;
    logic           in_range;
    logic           req_starts;

    assign shift    = (state_reg == ST_SCAN) || (state_reg == ST_SPREAD) ||
                      (state_reg == ST_LISTEN) || (state_reg == ST_READ);
    assign step_hit = wcd_pkg::idx_t'(step_reg) == idx_reg;
    assign odd      = wcd_pkg::walsh_odd(idx_reg, wcd_pkg::idx_t'(step_reg));
    assign delta    = wcd_pkg::delta_t'(new_sym_reg) - wcd_pkg::delta_t'(old_sym_reg);
    assign term     = wcd_pkg::acc_t'(chip_w[0]);
    assign acc_sum  = odd ? (acc_reg - term) : (acc_reg + term);
    assign acc_abs  = acc_sum[wcd_pkg::ACC_W-1] ? (wcd_pkg::acc_t'(0) - acc_sum) : acc_sum;
    assign quo_ext  = wcd_pkg::chip_t'(quotient);
    assign in_range = {1'b0, req.station} < (wcd_pkg::IDX_W + 1)'(STATIONS);

    // request that leaves idle: in range and a defined command
    assign req_starts = req.valid && req.ready && in_range &&
                        (req.command <= wcd_pkg::CMD_READ);

    // cell 0 is the head; its contents re-enter the ring at the far end
    always_comb
    begin
        ring_chip_in = chip_w[0];
        ring_sym_in  = sym_w[0];
        if (state_reg == ST_SCAN && step_hit)
        begin
            ring_sym_in = new_sym_reg;
        end
        if (state_reg == ST_SPREAD)
        begin
            ring_chip_in = odd ? (chip_w[0] - wcd_pkg::chip_t'(delta))
                               : (chip_w[0] + wcd_pkg::chip_t'(delta));
        end
    end

    for (genvar k = 0; k < STATIONS; k++)
    begin : g_ring
        if (k == STATIONS - 1)
        begin : g_tail
            wcd_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .shift   (shift),
                .chip_in (ring_chip_in),
                .sym_in  (ring_sym_in),
                .chip    (chip_w[k]),
                .sym     (sym_w[k])
            );
        end
        else
        begin : g_body
            wcd_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .shift   (shift),
                .chip_in (chip_w[k+1]),
                .sym_in  (sym_w[k+1]),
                .chip    (chip_w[k]),
                .sym     (sym_w[k])
            );
        end
    end

    assign div_start = (state_reg == ST_LISTEN) && (step_reg == STEP_LAST);

    wcd_div #(
        .STATIONS (STATIONS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (acc_abs[wcd_pkg::MAG_W-1:0]),
        .done     (div_done),
        .quotient (quotient)
    );

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        idx_next       = idx_reg;
        new_sym_next   = new_sym_reg;
        old_sym_next   = old_sym_reg;
        acc_next       = acc_reg;
        neg_next       = neg_reg;
        res_kind_next  = res_kind_reg;
        res_value_next = res_value_reg;
        out_kind_next  = out_kind_reg;
        out_value_next = out_value_reg;
        out_valid_next = out_valid_reg && !rsp.ready;

        if (shift)
        begin
            step_next = (step_reg == STEP_LAST) ? '0 : step_reg + 1'b1;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    idx_next     = req.station;
                    new_sym_next = wcd_pkg::sym_decode(req.symbol);
                    acc_next     = '0;
                    step_next    = '0;
                    if (in_range)
                    begin
                        priority case (req.command)
                            wcd_pkg::CMD_WRITE:  state_next = ST_SCAN;
                            wcd_pkg::CMD_LISTEN: state_next = ST_LISTEN;
                            wcd_pkg::CMD_READ:   state_next = ST_READ;
                            default:             state_next = ST_IDLE;
                        endcase
                    end
                end
            end
            ST_SCAN:
            begin
                if (step_hit)
                begin
                    old_sym_next = sym_w[0];
                end
                if (step_reg == STEP_LAST)
                begin
                    state_next = ST_SPREAD;
                end
            end
            ST_SPREAD:
            begin
                if (step_reg == STEP_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_LISTEN:
            begin
                acc_next = acc_sum;
                if (step_reg == STEP_LAST)
                begin
                    neg_next   = acc_sum[wcd_pkg::ACC_W-1];
                    state_next = ST_DIVIDE;
                end
            end
            ST_READ:
            begin
                if (step_hit)
                begin
                    res_kind_next  = wcd_pkg::KIND_CHIP;
                    res_value_next = chip_w[0];
                end
                if (step_reg == STEP_LAST)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_DIVIDE:
            begin
                if (div_done)
                begin
                    res_kind_next  = wcd_pkg::KIND_SYMBOL;
                    res_value_next = neg_reg ? (wcd_pkg::chip_t'(0) - quo_ext) : quo_ext;
                    state_next     = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                // wait for the output register to drain
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = res_kind_reg;
                    out_value_next = res_value_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        new_sym_reg   <= new_sym_next;
        old_sym_reg   <= old_sym_next;
        acc_reg       <= acc_next;
        neg_reg       <= neg_next;
        res_kind_reg  <= res_kind_next;
        res_value_reg <= res_value_next;
        out_kind_reg  <= out_kind_next;
        out_value_reg <= out_value_next;
    end

    assign req.ready = (state_reg == ST_IDLE);
    assign rsp.valid = out_valid_reg;
    assign rsp.kind  = out_kind_reg;
    assign rsp.value = out_value_reg;

    `ASSERT_CLK(a_request_blocks_next, req_starts |=> !req.ready, "request taken while busy")
    `ASSERT_CLK(a_rsp_from_finish, $rose(rsp.valid) |-> $past(state_reg == ST_FINISH), "response without finished request")
    `ASSERT_NEVER(a_step_range, step_reg > STEP_LAST, "ring step past last station")
    `ASSERT_CLK(a_div_done_in_divide, div_done |-> (state_reg == ST_DIVIDE), "divider finished outside divide")
    `ASSERT_CLK(a_ring_stops_idle, (state_reg == ST_IDLE) |-> (step_reg == '0), "ring left misaligned")

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// self-checking testbench of walsh_cdma_spread_despread: directed and random requests
// with random stalls on both channels, checked against an in-bench walsh spreading model
// depends on wcd_pkg, wcd_req_if, wcd_rsp_if and the rtl top level

module testbench;
    import wcd_pkg::*;

    localparam int STATIONS    = STATIONS_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 40;

    typedef struct packed {
        logic  kind;
        chip_t value;
    } reply_t;

    logic clk;
    logic rst_n;

    wcd_req_if req_ch ();
    wcd_rsp_if rsp_ch ();

    walsh_cdma_spread_despread #(
        .STATIONS(STATIONS)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_ch),
        .rsp  (rsp_ch)
    );

    // model state
    int     model_symbols [STATIONS];
    int     model_chips [STATIONS];
    reply_t pending_replies [$];

    int error_count;
    int cycle_count;
    bit send_idling;
    bit recv_idling;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // +1 when popcount(row & col) is even, -1 when odd
    function automatic int code_chip(int row, int col);
        int bits;
        int parity;
        bits   = row & col;
        parity = 0;
        while (bits != 0)
        begin
            parity ^= bits & 1;
            bits >>= 1;
        end
        return parity ? -1 : 1;
    endfunction

    function automatic void spread_model_step(cmd_t cmd, idx_t idx, logic [SYM_W-1:0] bits);
        int sym;
        int delta;
        int acc;
        reply_t r;
        if (int'(idx) >= STATIONS)
            return;
        case (cmd)
            CMD_WRITE:
            begin
                if (bits == 2'b01)
                    sym = 1;
                else if (bits == 2'b00)
                    sym = 0;
                else
                    sym = -1;
                delta = sym - model_symbols[idx];
                model_symbols[idx] = sym;
                for (int j = 0; j < STATIONS; j++)
                    model_chips[j] += delta * code_chip(idx, j);
            end
            CMD_LISTEN:
            begin
                acc = 0;
                for (int j = 0; j < STATIONS; j++)
                    acc += code_chip(idx, j) * model_chips[j];
                r.kind  = KIND_SYMBOL;
                r.value = chip_t'(acc / STATIONS);
                pending_replies.push_back(r);
            end
            CMD_READ:
            begin
                r.kind  = KIND_CHIP;
                r.value = chip_t'(model_chips[idx]);
                pending_replies.push_back(r);
            end
            default:
            begin
            end
        endcase
    endfunction

    task automatic flag_mismatch(string what);
        error_count++;
        $display("mismatch at cycle %0d: %s", cycle_count, what);
    endtask

    // one request; valid stays high across back-to-back requests
    task automatic send_request(cmd_t cmd, idx_t idx, logic [SYM_W-1:0] bits);
        int gap;
        gap = send_idling ? $urandom_range(0, 7) : 0;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.command <= cmd;
        req_ch.station <= idx;
        req_ch.symbol  <= bits;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        spread_model_step(cmd, idx, bits);
    endtask

    task automatic wait_for_replies();
        while (pending_replies.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_reset_state();
        for (int i = 0; i < STATIONS; i++)
            send_request(CMD_READ, idx_t'(i), 2'b00);
        send_request(CMD_LISTEN, idx_t'(STATIONS - 1), 2'b00);
    endtask

    task automatic test_spread_and_listen();
        send_request(CMD_WRITE, idx_t'(0), 2'b01);
        send_request(CMD_WRITE, idx_t'(1), 2'b11);
        // the -2 pattern saturates to -1
        send_request(CMD_WRITE, idx_t'(2), 2'b10);
        send_request(CMD_WRITE, idx_t'(STATIONS - 1), 2'b01);
        for (int i = 0; i < STATIONS; i++)
            send_request(CMD_READ, idx_t'(i), 2'b11);
        for (int i = 0; i < STATIONS; i++)
            send_request(CMD_LISTEN, idx_t'(i), 2'b10);
        // station 1 back to the zero symbol
        send_request(CMD_WRITE, idx_t'(1), 2'b00);
        send_request(CMD_LISTEN, idx_t'(1), 2'b00);
    endtask

    task automatic test_ignored_requests();
        send_request(CMD_WRITE, idx_t'(STATIONS), 2'b01);
        send_request(CMD_LISTEN, idx_t'(63), 2'b11);
        send_request(CMD_READ, idx_t'(63), 2'b00);
        send_request(cmd_t'(2'b11), idx_t'(0), 2'b01);
        send_request(CMD_READ, idx_t'(0), 2'b00);
    endtask

    // mostly in-range traffic, a tenth noise with any field value
    task automatic test_random_traffic(int count);
        int   pick;
        cmd_t cmd;
        idx_t idx;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 10)
            begin
                cmd = cmd_t'($urandom_range(0, 3));
                idx = idx_t'($urandom_range(0, 63));
            end
            else
            begin
                if (pick < 55)
                    cmd = CMD_WRITE;
                else if (pick < 80)
                    cmd = CMD_LISTEN;
                else
                    cmd = CMD_READ;
                idx = idx_t'($urandom_range(0, STATIONS - 1));
            end
            send_request(cmd, idx, SYM_W'($urandom_range(0, 3)));
        end
    endtask

    // sender holds off until the response channel has drained
    task automatic test_drain_pause();
        send_request(CMD_WRITE, idx_t'(2), 2'b11);
        send_request(CMD_LISTEN, idx_t'(2), 2'b00);
        send_request(CMD_READ, idx_t'(0), 2'b00);
        req_ch.valid <= 1'b0;
        wait_for_replies();
        send_request(CMD_LISTEN, idx_t'(0), 2'b00);
    endtask

    // response side: random stall per response while recv_idling is set, then check against the oldest expectation
    initial
    begin
        int     stall;
        reply_t exp;
        rsp_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            stall = recv_idling ? $urandom_range(0, 7) : 0;
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge clk);
            while (!(rsp_ch.valid && rsp_ch.ready))
                @(posedge clk);
            if (pending_replies.size() == 0)
                flag_mismatch($sformatf("unexpected response kind %0d value %0d",
                                        rsp_ch.kind, rsp_ch.value));
            else
            begin
                exp = pending_replies.pop_front();
                if (rsp_ch.kind !== exp.kind)
                    flag_mismatch($sformatf("kind %0d, expected %0d", rsp_ch.kind, exp.kind));
                if (rsp_ch.value !== exp.value)
                    flag_mismatch($sformatf("value %0d, expected %0d",
                                            rsp_ch.value, exp.value));
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        error_count = 0;
        send_idling = 1'b1;
        recv_idling = 1'b1;
        for (int i = 0; i < STATIONS; i++)
        begin
            model_symbols[i] = 0;
            model_chips[i]   = 0;
        end
        rst_n          <= 1'b0;
        req_ch.valid   <= 1'b0;
        req_ch.command <= CMD_WRITE;
        req_ch.station <= '0;
        req_ch.symbol  <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_spread_and_listen();
        test_ignored_requests();
        test_drain_pause();

        test_random_traffic(600);
        send_idling = 1'b0;
        recv_idling = 1'b0;
        test_random_traffic(300);
        recv_idling = 1'b1;
        test_random_traffic(250);
        send_idling = 1'b1;
        recv_idling = 1'b0;
        test_random_traffic(250);
        recv_idling = 1'b1;
        test_drain_pause();
        test_random_traffic(200);

        req_ch.valid <= 1'b0;
        wait_for_replies();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== walsh_cdma_spread_despread.f =====
+incdir+hw/rtl
hw/rtl/wcd_pkg.sv
hw/rtl/wcd_if.sv
hw/rtl/wcd_cell.sv
hw/rtl/wcd_div.sv
hw/rtl/walsh_cdma_spread_despread.sv
test/testbench.sv
